// ===== rtl/pta_pkg.sv =====
// Shared types and constants for the primitive-to-triangle assembly block.
// Used by pta_front, pta_queue, pta_back and primitive_to_triangle_assembly.
// No dependencies.
package pta_pkg;

    // Significant bits of a vertex index (the port width stays at FIELD_WIDTH)
    localparam int IDX_WIDTH   = 32;
    localparam int FIELD_WIDTH = 32;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    typedef logic [IDX_WIDTH-1:0] idx_t;

    // Assembly modes
    typedef enum logic [1:0] {
        MODE_LIST  = 2'd0,
        MODE_STRIP = 2'd1,
        MODE_QUAD  = 2'd2
    } mode_t;

    // Mode code that a configuration write may carry but that is refused
    localparam logic [1:0] MODE_REFUSED = 2'd3;

    // Position codes within a group
    localparam logic [1:0] PHASE_FIRST = 2'd0;
    localparam logic [1:0] PHASE_THIRD = 2'd2;
    localparam logic [1:0] PHASE_LAST  = 2'd3;

    // One queued command: a single triangle (w0,w1,w2), or a quad that
    // splits into (w0,w1,w2) and (w0,w2,w3)
    typedef struct packed {
        idx_t w0;
        idx_t w1;
        idx_t w2;
        idx_t w3;
        logic quad;
    } entry_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== rtl/pta_front.sv =====
// Front end: accepts index requests and configuration writes, keeps the run
// state and turns each closed group or window into a queue command.
// Depends on pta_pkg.
module pta_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    // index channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pta_pkg::FIELD_WIDTH-1:0] s_vertex_index,
    input  logic                            s_list_end,
    // configuration channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_primitive_mode,
    // queue side
    input  pta_pkg::q_status_t              q_stat,
    output logic                            q_push,
    output pta_pkg::entry_t                 q_push_data
);

    pta_pkg::mode_t mode_reg, mode_next;
    logic [1:0]     phase_reg, phase_next;
    logic           filled_reg, filled_next;
    pta_pkg::idx_t  h0_reg, h0_next;
    pta_pkg::idx_t  h1_reg, h1_next;
    pta_pkg::idx_t  h2_reg, h2_next;

    pta_pkg::idx_t  v;
    logic           item_acc;
    logic           emit;
    logic           degenerate;

    assign cfg_ready = 1'b1;
    // index requests wait while a configuration request is taken
    assign s_ready   = !q_stat.full && !cfg_valid;
    assign item_acc  = s_valid && s_ready;
    assign v         = s_vertex_index[pta_pkg::IDX_WIDTH-1:0];
    assign degenerate = (h0_reg == h1_reg) || (h1_reg == v) || (h0_reg == v);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= pta_pkg::MODE_LIST;
            phase_reg  <= pta_pkg::PHASE_FIRST;
            filled_reg <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            phase_reg  <= phase_next;
            filled_reg <= filled_next;
        end
    end

    // held indices (only read once written within a run)
    always_ff @(posedge aclk) begin
        h0_reg <= h0_next;
        h1_reg <= h1_next;
        h2_reg <= h2_next;
    end

    // classify the incoming index
    always_comb begin
        mode_next   = mode_reg;
        phase_next  = phase_reg;
        filled_next = filled_reg;
        h0_next     = h0_reg;
        h1_next     = h1_reg;
        h2_next     = h2_reg;
        emit        = 1'b0;
        q_push_data = '{w0: h0_reg, w1: h1_reg, w2: v, w3: v, quad: 1'b0};

        if (cfg_valid) begin
            // refused code leaves everything as it is
            if (cfg_primitive_mode != pta_pkg::MODE_REFUSED) begin
                mode_next   = pta_pkg::mode_t'(cfg_primitive_mode);
                phase_next  = pta_pkg::PHASE_FIRST;
                filled_next = 1'b0;
            end
        end else if (item_acc) begin
            case (mode_reg)
                pta_pkg::MODE_LIST: begin
                    if (phase_reg >= pta_pkg::PHASE_THIRD) begin
                        emit       = 1'b1;
                        phase_next = pta_pkg::PHASE_FIRST;
                    end else begin
                        if (phase_reg == pta_pkg::PHASE_FIRST) h0_next = v;
                        else h1_next = v;
                        phase_next = phase_reg + 2'd1;
                    end
                end
                pta_pkg::MODE_STRIP: begin
                    if (filled_reg) begin
                        emit = !degenerate;
                        // odd window start swaps the last two corners
                        if (phase_reg[0]) begin
                            q_push_data.w1 = v;
                            q_push_data.w2 = h1_reg;
                        end
                        h0_next = h1_reg;
                        h1_next = v;
                    end else if (phase_reg == pta_pkg::PHASE_FIRST) begin
                        h0_next = v;
                    end else begin
                        h1_next     = v;
                        filled_next = 1'b1;
                    end
                    phase_next = phase_reg + 2'd1;
                end
                pta_pkg::MODE_QUAD: begin
                    if (phase_reg == pta_pkg::PHASE_LAST) begin
                        emit        = 1'b1;
                        q_push_data = '{w0: h0_reg, w1: h1_reg, w2: h2_reg, w3: v,
                                        quad: 1'b1};
                        phase_next  = pta_pkg::PHASE_FIRST;
                    end else begin
                        case (phase_reg)
                            pta_pkg::PHASE_FIRST: h0_next = v;
                            pta_pkg::PHASE_THIRD: h2_next = v;
                            default:              h1_next = v;
                        endcase
                        phase_next = phase_reg + 2'd1;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase

            // list end drops any partial group
            if (s_list_end) begin
                phase_next  = pta_pkg::PHASE_FIRST;
                filled_next = 1'b0;
            end
        end
    end

    assign q_push = item_acc && !cfg_valid && emit;

endmodule

// ===== rtl/pta_queue.sv =====
// Small command queue between front and back, built from registers.
// Depends on pta_pkg.
module pta_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  pta_pkg::entry_t    push_data,
    input  logic               pop,
    output pta_pkg::entry_t    pop_data,
    output pta_pkg::q_status_t stat
);

    pta_pkg::entry_t                 slot_reg [pta_pkg::QUEUE_DEPTH];
    logic [pta_pkg::QPTR_WIDTH-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [pta_pkg::QPTR_WIDTH-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [pta_pkg::QCNT_WIDTH-1:0]  count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign stat.full  = (count_reg == pta_pkg::QCNT_WIDTH'(pta_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == pta_pkg::QPTR_WIDTH'(pta_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == pta_pkg::QPTR_WIDTH'(pta_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/pta_back.sv =====
// Back end: pops queue commands and drives the triangle channel through an
// output register; quad commands are sent as two triangles.
// Depends on pta_pkg.
module pta_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  pta_pkg::q_status_t              q_stat,
    input  pta_pkg::entry_t                 q_pop_data,
    output logic                            q_pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pta_pkg::FIELD_WIDTH-1:0] m_corner_a,
    output logic [pta_pkg::FIELD_WIDTH-1:0] m_corner_b,
    output logic [pta_pkg::FIELD_WIDTH-1:0] m_corner_c,
    output logic                            m_last_of_run
);

    logic          valid_reg, valid_next;
    logic          pend_reg, pend_next;
    pta_pkg::idx_t a_reg, a_next;
    pta_pkg::idx_t b_reg, b_next;
    pta_pkg::idx_t c_reg, c_next;
    logic          last_reg, last_next;
    // second half of a quad: (w0, w2, w3)
    pta_pkg::idx_t pa_reg, pa_next;
    pta_pkg::idx_t pb_reg, pb_next;
    pta_pkg::idx_t pc_reg, pc_next;
    logic          out_free;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        last_next  = last_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        pc_next    = pc_reg;
        q_pop      = 1'b0;
        if (out_free) begin
            if (pend_reg) begin
                a_next     = pa_reg;
                b_next     = pb_reg;
                c_next     = pc_reg;
                last_next  = 1'b1;
                pend_next  = 1'b0;
                valid_next = 1'b1;
            end else if (!q_stat.empty) begin
                q_pop      = 1'b1;
                a_next     = q_pop_data.w0;
                b_next     = q_pop_data.w1;
                c_next     = q_pop_data.w2;
                last_next  = !q_pop_data.quad;
                pend_next  = q_pop_data.quad;
                pa_next    = q_pop_data.w0;
                pb_next    = q_pop_data.w2;
                pc_next    = q_pop_data.w3;
                valid_next = 1'b1;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        last_reg <= last_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        pc_reg   <= pc_next;
    end

    assign m_valid       = valid_reg;
    assign m_corner_a    = pta_pkg::FIELD_WIDTH'(a_reg);
    assign m_corner_b    = pta_pkg::FIELD_WIDTH'(b_reg);
    assign m_corner_c    = pta_pkg::FIELD_WIDTH'(c_reg);
    assign m_last_of_run = last_reg;

endmodule

// ===== rtl/primitive_to_triangle_assembly.sv =====
// Top level of the primitive-to-triangle assembly block.
// Depends on pta_pkg, pta_front, pta_queue and pta_back.
//
// Usage:
//   s_ channel: one vertex index per request, s_list_end on the last index
//   of a list. m_ channel: one triangle per request (three corners), with
//   m_last_of_run high on the final triangle that an index produced.
//   cfg channel: writes the assembly mode (0 list, 1 strip, 2 quads); code 3
//   is ignored. cfg_ready is always high and s_ready is held low during a
//   configuration request; write only while the block is idle.
//   Throughput: one index per cycle while s_ready is high. A quad index yields
//   two triangles, which leave the output register one after the other, so
//   closing quad indices drain more slowly than they can be taken; the
//   four-entry command queue absorbs short bursts before s_ready drops.
//   Pipeline: two register stages; the queue takes the closing index at the
//   edge that accepts it, and the output register loads it from the queue
//   once the register is free, which raises m_valid.
//   Reset (aresetn low, synchronous): mode returns to triangle list, run
//   state and queue clear, m_valid drops.
//   Receiver stall: the output register holds its triangle; the queue fills
//   and then s_ready goes low until the receiver resumes.
module primitive_to_triangle_assembly (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pta_pkg::FIELD_WIDTH-1:0] s_vertex_index,
    input  logic                            s_list_end,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_primitive_mode,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pta_pkg::FIELD_WIDTH-1:0] m_corner_a,
    output logic [pta_pkg::FIELD_WIDTH-1:0] m_corner_b,
    output logic [pta_pkg::FIELD_WIDTH-1:0] m_corner_c,
    output logic                            m_last_of_run
);

    pta_pkg::q_status_t q_stat;
    pta_pkg::entry_t    q_push_data;
    pta_pkg::entry_t    q_pop_data;
    logic               q_push;
    logic               q_pop;

    pta_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_vertex_index     (s_vertex_index),
        .s_list_end         (s_list_end),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_primitive_mode (cfg_primitive_mode),
        .q_stat             (q_stat),
        .q_push             (q_push),
        .q_push_data        (q_push_data)
    );

    pta_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .stat      (q_stat)
    );

    pta_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_stat        (q_stat),
        .q_pop_data    (q_pop_data),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_corner_a    (m_corner_a),
        .m_corner_b    (m_corner_b),
        .m_corner_c    (m_corner_c),
        .m_last_of_run (m_last_of_run)
    );

    // front never pushes into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn) !(q_push && q_stat.full))
        else $error("command pushed into full queue");

    // back never pops an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn) !(q_pop && q_stat.empty))
        else $error("command popped from empty queue");

    // first half of a quad is always followed by its second half
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last_of_run) |=> m_valid)
        else $error("quad second triangle missing");

    // a new triangle after the first half of a quad must close the run
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run) |=> m_last_of_run)
        else $error("quad second triangle not marked last");

endmodule

// ===== test/tb.sv =====
// Testbench for primitive_to_triangle_assembly: directed and random index streams in
// list, strip and quad modes, checked triangle by triangle against an in-bench predictor.
// Depends on pta_pkg and the primitive_to_triangle_assembly RTL.
module tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int ITEMS_PER_RUN = 195;

    typedef struct {
        logic [pta_pkg::FIELD_WIDTH-1:0] a;
        logic [pta_pkg::FIELD_WIDTH-1:0] b;
        logic [pta_pkg::FIELD_WIDTH-1:0] c;
        logic                            last;
    } triangle_t;

    logic                            aclk               = 1'b0;
    logic                            aresetn            = 1'b0;
    logic                            s_valid            = 1'b0;
    logic                            s_ready;
    logic [pta_pkg::FIELD_WIDTH-1:0] s_vertex_index     = '0;
    logic                            s_list_end         = 1'b0;
    logic                            cfg_valid          = 1'b0;
    logic                            cfg_ready;
    logic [1:0]                      cfg_primitive_mode = pta_pkg::MODE_LIST;
    logic                            m_valid;
    logic                            m_ready            = 1'b0;
    logic [pta_pkg::FIELD_WIDTH-1:0] m_corner_a;
    logic [pta_pkg::FIELD_WIDTH-1:0] m_corner_b;
    logic [pta_pkg::FIELD_WIDTH-1:0] m_corner_c;
    logic                            m_last_of_run;

    // Idle percentages for the request sender and the triangle receiver
    int send_idle_pct = 25;
    int recv_idle_pct = 67;
    int errors        = 0;
    int cycles        = 0;

    // Predictor state: mode, held corners, group position, strip window flag
    pta_pkg::mode_t asm_mode;
    pta_pkg::idx_t  held [3];
    logic [1:0]     phase;
    logic           window_full;

    triangle_t expected_tris [$];

    primitive_to_triangle_assembly dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_vertex_index     (s_vertex_index),
        .s_list_end         (s_list_end),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_primitive_mode (cfg_primitive_mode),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_corner_a         (m_corner_a),
        .m_corner_b         (m_corner_b),
        .m_corner_c         (m_corner_c),
        .m_last_of_run      (m_last_of_run)
    );

    // Clock, period 2
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Receiver stalls at random
    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void clear_run_state();
        held[0]     = '0;
        held[1]     = '0;
        held[2]     = '0;
        phase       = pta_pkg::PHASE_FIRST;
        window_full = 1'b0;
    endfunction

    function automatic void add_expected(pta_pkg::idx_t a, pta_pkg::idx_t b,
                                         pta_pkg::idx_t c, logic last);
        triangle_t t;
        t.a    = pta_pkg::FIELD_WIDTH'(a);
        t.b    = pta_pkg::FIELD_WIDTH'(b);
        t.c    = pta_pkg::FIELD_WIDTH'(c);
        t.last = last;
        expected_tris.insert(expected_tris.size(), t);
    endfunction

    // Triangles produced by one accepted index
    function automatic void assemble_triangles(pta_pkg::idx_t v, logic last_idx);
        logic [1:0]    ph;
        pta_pkg::idx_t a;
        pta_pkg::idx_t b;
        ph = phase;
        case (asm_mode)
            pta_pkg::MODE_LIST: begin
                if (ph >= pta_pkg::PHASE_THIRD) begin
                    add_expected(held[0], held[1], v, 1'b1);
                    phase = pta_pkg::PHASE_FIRST;
                end else begin
                    held[ph] = v;
                    phase    = ph + 2'd1;
                end
            end
            pta_pkg::MODE_STRIP: begin
                if (window_full) begin
                    a = held[0];
                    b = held[1];
                    // degenerate window: no triangle, window still slides
                    if (!(a == b || b == v || a == v)) begin
                        if (ph[0] == 1'b0) begin
                            add_expected(a, b, v, 1'b1);
                        end else begin
                            add_expected(a, v, b, 1'b1);
                        end
                    end
                    held[0] = b;
                    held[1] = v;
                end else if (ph == pta_pkg::PHASE_FIRST) begin
                    held[0] = v;
                end else begin
                    held[1]     = v;
                    window_full = 1'b1;
                end
                phase = ph + 2'd1;
            end
            default: begin
                if (ph == pta_pkg::PHASE_LAST) begin
                    add_expected(held[0], held[1], held[2], 1'b0);
                    add_expected(held[0], held[2], v, 1'b1);
                    phase = pta_pkg::PHASE_FIRST;
                end else begin
                    held[ph] = v;
                    phase    = ph + 2'd1;
                end
            end
        endcase
        if (last_idx) clear_run_state();
    endfunction

    function automatic void check_field(string name,
                                        logic [pta_pkg::FIELD_WIDTH-1:0] want,
                                        logic [pta_pkg::FIELD_WIDTH-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare each delivered triangle with the oldest prediction
    always @(posedge aclk) begin : check_results
        triangle_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_tris.size() == 0) begin
                $display("%0t: unexpected triangle, expected none, actual %h %h %h last %b",
                         $time, m_corner_a, m_corner_b, m_corner_c, m_last_of_run);
                errors++;
            end else begin
                want = expected_tris.pop_front();
                check_field("corner_a", want.a, m_corner_a);
                check_field("corner_b", want.b, m_corner_b);
                check_field("corner_c", want.c, m_corner_c);
                check_field("last_of_run", pta_pkg::FIELD_WIDTH'(want.last),
                            pta_pkg::FIELD_WIDTH'(m_last_of_run));
            end
        end
    end

    // One index request, with random idle cycles ahead of it
    task automatic send_index(input logic [pta_pkg::FIELD_WIDTH-1:0] value,
                              input logic last_idx);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_vertex_index = value;
        s_list_end     = last_idx;
        do @(posedge aclk); while (!s_ready);
        assemble_triangles(value[pta_pkg::IDX_WIDTH-1:0], last_idx);
    endtask

    // Stop sending and wait until every predicted triangle has arrived
    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_tris.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic [1:0] code);
        wait_drained();
        @(negedge aclk);
        cfg_valid          = 1'b1;
        cfg_primitive_mode = code;
        do @(posedge aclk); while (!cfg_ready);
        if (code != pta_pkg::MODE_REFUSED) begin
            asm_mode = pta_pkg::mode_t'(code);
            clear_run_state();
        end
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Small values make strip degeneracies common; extremes now and then
    function automatic logic [pta_pkg::FIELD_WIDTH-1:0] random_index();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) return pta_pkg::FIELD_WIDTH'($urandom_range(7));
        if (pick < 45) return '0;
        if (pick < 50) return '1;
        return $urandom;
    endfunction

    // Mostly well-formed lists with random content, some cut short or ragged
    task automatic send_random_lists(input int n_items);
        int sent;
        int len;
        int grp;
        int k;
        logic cut;
        sent = 0;
        grp  = (asm_mode == pta_pkg::MODE_QUAD) ? 4 : 3;
        while (sent < n_items) begin
            if ($urandom_range(99) < 70) begin
                len = (asm_mode == pta_pkg::MODE_STRIP) ? $urandom_range(12, 3)
                                                        : grp * $urandom_range(4, 1);
            end else begin
                len = $urandom_range(10, 1);
            end
            for (k = 0; k < len; k++) begin
                cut = ($urandom_range(49) == 0);
                send_index(random_index(), (k == len - 1) || cut);
            end
            sent += len;
        end
    endtask

    task automatic test_list_mode();
        write_mode(pta_pkg::MODE_LIST);
        send_index(32'h0000_0000, 1'b0);
        send_index(32'hFFFF_FFFF, 1'b0);
        send_index(32'hAAAA_AAAA, 1'b0);
        // partial group dropped at list end
        send_index(32'h5555_5555, 1'b0);
        send_index(32'h0000_0001, 1'b1);
    endtask

    task automatic test_strip_mode();
        write_mode(pta_pkg::MODE_STRIP);
        // even and odd window starts alternate the winding
        send_index(32'd10, 1'b0);
        send_index(32'd11, 1'b0);
        send_index(32'd12, 1'b0);
        send_index(32'd13, 1'b0);
        send_index(32'd14, 1'b1);
        // degenerate windows: first two equal, first and last equal, last two equal
        send_index(32'd5, 1'b0);
        send_index(32'd5, 1'b0);
        send_index(32'd6, 1'b0);
        send_index(32'd5, 1'b0);
        send_index(32'd7, 1'b0);
        send_index(32'd7, 1'b1);
    endtask

    task automatic test_quad_mode();
        write_mode(pta_pkg::MODE_QUAD);
        send_index(32'h0000_0000, 1'b0);
        send_index(32'hFFFF_FFFF, 1'b0);
        send_index(32'h0000_0001, 1'b0);
        send_index(32'h0000_0002, 1'b0);
        send_index(32'h0000_0003, 1'b0);
        send_index(32'h0000_0004, 1'b1);
    endtask

    // Refused code keeps mode and held corners; a real write clears the run
    task automatic test_mode_writes();
        write_mode(pta_pkg::MODE_LIST);
        send_index(32'd100, 1'b0);
        send_index(32'd101, 1'b0);
        write_mode(pta_pkg::MODE_REFUSED);
        send_index(32'd102, 1'b0);
        send_index(32'd103, 1'b0);
        write_mode(pta_pkg::MODE_LIST);
        send_index(32'd104, 1'b0);
        send_index(32'd105, 1'b0);
        send_index(32'd106, 1'b1);
    endtask

    // Random lists in each mode; a refused write mid-list pauses until drained
    task automatic test_random_streams(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_mode(pta_pkg::MODE_LIST);
        send_random_lists(ITEMS_PER_RUN);
        write_mode(pta_pkg::MODE_STRIP);
        send_random_lists(ITEMS_PER_RUN / 2);
        send_index(random_index(), 1'b0);
        write_mode(pta_pkg::MODE_REFUSED);
        send_random_lists(ITEMS_PER_RUN / 2);
        write_mode(pta_pkg::MODE_QUAD);
        send_random_lists(ITEMS_PER_RUN);
    endtask

    initial begin
        asm_mode = pta_pkg::MODE_LIST;
        clear_run_state();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_list_mode();
        test_strip_mode();
        test_quad_mode();
        test_mode_writes();
        test_random_streams(25, 67);
        test_random_streams(67, 25);
        test_random_streams(0, 0);

        wait_drained();
        if (errors == 0 && expected_tris.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== primitive_to_triangle_assembly.f =====
rtl/pta_pkg.sv
rtl/pta_front.sv
rtl/pta_queue.sv
rtl/pta_back.sv
rtl/primitive_to_triangle_assembly.sv
test/tb.sv
